@@ rtl/ufsp_pkg.sv @@
// ufsp_pkg: shared types and codes for the framed UTF-8 symbol parser.
// No dependencies; imported by the front, queue, back and top modules.
package ufsp_pkg;

  localparam logic [7:0] MARK_START       = 8'h81;
  localparam logic [7:0] MARK_END         = 8'h82;
  localparam logic [7:0] MARK_BLOCK_OPEN  = 8'h83;
  localparam logic [7:0] MARK_BLOCK_CLOSE = 8'h84;
  localparam logic [7:0] MARK_RULE        = 8'h85;

  localparam int unsigned CODE_W = 21;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned ERR_W  = 3;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [3:0] {
    CLS_START,
    CLS_END,
    CLS_OPEN,
    CLS_CLOSE,
    CLS_RULE,
    CLS_ASCII,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_BAD
  } byte_class_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_BODY      = 3'd0,
    KIND_HEAD      = 3'd1,
    KIND_BLOCK_END = 3'd2,
    KIND_TX_END    = 3'd3,
    KIND_ERROR     = 3'd4
  } event_kind_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_REPEAT_START = 3'd0,
    ERR_NESTED_BLOCK = 3'd1,
    ERR_BAD_CLOSE    = 3'd2,
    ERR_BAD_UTF8     = 3'd3,
    ERR_END_NO_START = 3'd4,
    ERR_OUTSIDE      = 3'd5
  } error_code_t;

  // one classified word as it travels from front to back
  typedef struct packed {
    byte_class_t cls;
    logic        is_cont;
    logic [7:0]  data;
  } entry_t;

endpackage

@@ rtl/ufsp_byte_if.sv @@
// ufsp_byte_if: valid/ready channel carrying one input byte per word.
// No dependencies.
interface ufsp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

@@ rtl/ufsp_event_if.sv @@
// ufsp_event_if: valid/ready channel carrying one parser event per word.
// No dependencies.
interface ufsp_event_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [20:0] symbol_value;
  logic [2:0]  error_code;

  modport source (output valid, output event_kind, output symbol_value,
                  output error_code, input ready);
  modport sink   (input valid, input event_kind, input symbol_value,
                  input error_code, output ready);
endinterface

@@ rtl/ufsp_front.sv @@
// ufsp_front: accepts input bytes, classifies them as marker, ASCII, lead or bad.
// Depends on ufsp_pkg and ufsp_byte_if; feeds ufsp_queue.
module ufsp_front import ufsp_pkg::*; (
  ufsp_byte_if.sink in_ch,
  output logic      push_valid,
  input  logic      push_ready,
  output entry_t    push_entry
);

  logic [7:0] b;

  assign b             = in_ch.in_byte;
  assign push_valid    = in_ch.valid;
  assign in_ch.ready   = push_ready;

  always_comb begin
    push_entry.data    = b;
    push_entry.is_cont = (b[7:6] == 2'b10);
    unique case (b)
      MARK_START:       push_entry.cls = CLS_START;
      MARK_END:         push_entry.cls = CLS_END;
      MARK_BLOCK_OPEN:  push_entry.cls = CLS_OPEN;
      MARK_BLOCK_CLOSE: push_entry.cls = CLS_CLOSE;
      MARK_RULE:        push_entry.cls = CLS_RULE;
      default: begin
        if (!b[7])                 push_entry.cls = CLS_ASCII;
        else if (b[7:5] == 3'b110) push_entry.cls = CLS_LEAD2;
        else if (b[7:4] == 4'b1110) push_entry.cls = CLS_LEAD3;
        else if (b[7:3] == 5'b11110) push_entry.cls = CLS_LEAD4;
        else                       push_entry.cls = CLS_BAD;
      end
    endcase
  end

endmodule

@@ rtl/ufsp_queue.sv @@
// ufsp_queue: two-word FIFO between classifier front and decoder back.
// Depends on ufsp_pkg.
module ufsp_queue import ufsp_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push_valid,
  output logic   push_ready,
  input  entry_t push_entry,
  output logic   pop_valid,
  input  logic   pop_ready,
  output entry_t pop_entry
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_entry  = mem[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

endmodule

@@ rtl/ufsp_back.sv @@
// ufsp_back: framing state and UTF-8 assembly; drives the registered event output.
// Depends on ufsp_pkg and ufsp_event_if; fed by ufsp_queue.
module ufsp_back import ufsp_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  entry_t        pop_entry,
  ufsp_event_if.source  out_ch
);

  logic              started_r, started_nxt;
  logic              in_block_r, in_block_nxt;
  logic              rule_pend_r, rule_pend_nxt;
  logic              has_data_r, has_data_nxt;
  logic [1:0]        cont_left_r, cont_left_nxt;
  logic [CODE_W-1:0] acc_r, acc_nxt;

  logic              out_valid_r, out_valid_nxt;
  event_kind_t       kind_r, kind_nxt;
  logic [CODE_W-1:0] value_r, value_nxt;
  error_code_t       err_r, err_nxt;

  logic              take;
  logic              emit;
  logic              emit_sym;
  logic              raise;
  logic              clear;
  event_kind_t       ev_kind;
  error_code_t       ev_err;
  logic [7:0]        b;

  assign b         = pop_entry.data;
  // take a word whenever the output slot is free or draining this cycle
  assign take      = pop_valid && (!out_valid_r || out_ch.ready);
  assign pop_ready = !out_valid_r || out_ch.ready;

  always_comb begin
    started_nxt   = started_r;
    in_block_nxt  = in_block_r;
    rule_pend_nxt = rule_pend_r;
    has_data_nxt  = has_data_r;
    cont_left_nxt = cont_left_r;
    acc_nxt       = acc_r;
    emit          = 1'b0;
    emit_sym      = 1'b0;
    raise         = 1'b0;
    clear         = 1'b0;
    ev_kind       = KIND_BODY;
    ev_err        = ERR_REPEAT_START;

    if (take) begin
      if (cont_left_r != 2'd0) begin
        if (!pop_entry.is_cont) begin
          raise  = 1'b1;
          ev_err = ERR_BAD_UTF8;
        end else begin
          acc_nxt       = {acc_r[CODE_W-7:0], b[5:0]};
          cont_left_nxt = cont_left_r - 2'd1;
          emit_sym      = (cont_left_r == 2'd1);
        end
      end else if (!started_r) begin
        if (pop_entry.cls == CLS_START) begin
          started_nxt = 1'b1;
        end else if (pop_entry.cls == CLS_END) begin
          raise  = 1'b1;
          ev_err = ERR_END_NO_START;
        end
      end else begin
        case (pop_entry.cls)
          CLS_START: begin
            raise  = 1'b1;
            ev_err = ERR_REPEAT_START;
          end
          CLS_END: begin
            clear   = 1'b1;
            emit    = 1'b1;
            ev_kind = KIND_TX_END;
          end
          CLS_OPEN: begin
            has_data_nxt = 1'b0;
            if (in_block_r) begin
              raise  = 1'b1;
              ev_err = ERR_NESTED_BLOCK;
            end else begin
              in_block_nxt  = 1'b1;
              rule_pend_nxt = 1'b1;
            end
          end
          CLS_CLOSE: begin
            if (!has_data_r || !in_block_r) begin
              raise  = 1'b1;
              ev_err = ERR_BAD_CLOSE;
            end else begin
              in_block_nxt  = 1'b0;
              rule_pend_nxt = 1'b0;
              emit          = 1'b1;
              ev_kind       = KIND_BLOCK_END;
            end
          end
          CLS_RULE: rule_pend_nxt = 1'b1;
          default: begin
            if (!in_block_r) begin
              raise  = 1'b1;
              ev_err = ERR_OUTSIDE;
            end else begin
              case (pop_entry.cls)
                CLS_ASCII: begin
                  acc_nxt  = CODE_W'(b);
                  emit_sym = 1'b1;
                end
                CLS_LEAD2: begin
                  acc_nxt       = CODE_W'(b[4:0]);
                  cont_left_nxt = 2'd1;
                end
                CLS_LEAD3: begin
                  acc_nxt       = CODE_W'(b[3:0]);
                  cont_left_nxt = 2'd2;
                end
                CLS_LEAD4: begin
                  acc_nxt       = CODE_W'(b[2:0]);
                  cont_left_nxt = 2'd3;
                end
                default: begin
                  raise  = 1'b1;
                  ev_err = ERR_BAD_UTF8;
                end
              endcase
            end
          end
        endcase
      end

      if (emit_sym) begin
        emit          = 1'b1;
        ev_kind       = rule_pend_r ? KIND_HEAD : KIND_BODY;
        rule_pend_nxt = 1'b0;
        has_data_nxt  = 1'b1;
      end
      if (raise) begin
        emit    = 1'b1;
        clear   = 1'b1;
        ev_kind = KIND_ERROR;
      end
      // drop all framing state back to waiting for a start marker
      if (clear) begin
        started_nxt   = 1'b0;
        in_block_nxt  = 1'b0;
        rule_pend_nxt = 1'b0;
        has_data_nxt  = 1'b0;
        cont_left_nxt = 2'd0;
        acc_nxt       = '0;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    kind_nxt      = kind_r;
    value_nxt     = value_r;
    err_nxt       = err_r;
    if (take && emit) begin
      out_valid_nxt = 1'b1;
      kind_nxt      = ev_kind;
      value_nxt     = emit_sym ? acc_nxt : '0;
      err_nxt       = raise ? ev_err : ERR_REPEAT_START;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r   <= 1'b0;
      in_block_r  <= 1'b0;
      rule_pend_r <= 1'b0;
      has_data_r  <= 1'b0;
      cont_left_r <= 2'd0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      started_r   <= started_nxt;
      in_block_r  <= in_block_nxt;
      rule_pend_r <= rule_pend_nxt;
      has_data_r  <= has_data_nxt;
      cont_left_r <= cont_left_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    value_r <= value_nxt;
    err_r   <= err_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.event_kind   = kind_r;
  assign out_ch.symbol_value = value_r;
  assign out_ch.error_code   = err_r;

endmodule

@@ rtl/utf8_framed_symbol_parser.sv @@
// Framed UTF-8 symbol parser: classifier front, two-word queue, decoder back.
// Path: an accepted byte is written into the queue; the back then takes it and
//   registers its event, if any. Throughput: one byte per cycle while the queue
//   has room; the back takes one word each cycle its output register is free or
//   draining. A stalled output fills the queue, which then holds the input off.
// Reset: synchronous active-low rst_n empties the queue and clears framing state.
module utf8_framed_symbol_parser import ufsp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  ufsp_byte_if.sink    in_ch,
  ufsp_event_if.source out_ch
);

  logic   push_valid, push_ready;
  entry_t push_entry;
  logic   pop_valid, pop_ready;
  entry_t pop_entry;

  ufsp_front u_front (
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  ufsp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  ufsp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry),
    .out_ch    (out_ch)
  );

endmodule
